>>> rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Types and character codes shared by the expression evaluator and its checker.
// ----------------------------------------------------------------------------
package iee_pkg;

    // Sequencer state
    typedef enum logic [1:0] {
        F_IDLE,
        F_STEP,
        F_MUL,
        F_DIV
    } fsm_t;

    // Scan phase of the parser
    typedef enum logic [2:0] {
        PH_FACT,
        PH_NUMB,
        PH_PSTART,
        PH_PNUMB,
        PH_PCLOSE,
        PH_TERM,
        PH_SUM
    } phase_t;

    // Operation applied when the current factor completes
    typedef enum logic [1:0] {
        OP_FIRST,
        OP_MUL,
        OP_DIV,
        OP_MOD
    } term_op_t;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

endpackage

>>> rtl/integer_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// integer_expression_evaluator_core
// Character-serial decimal expression evaluator (+ - * / %, implicit multiply),
// built on one shared shift-add multiplier / restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_char_code, s_end_of_input) arrive one character at a time
//   on a valid/ready channel. A word that finishes an expression (end of input
//   or a character that fits nowhere) produces one result word on the m_
//   channel: value, stop character (0 on end of input), end flag, and a flag
//   for division or modulo by zero. Other characters produce nothing.
//   Each character is accepted and then handled by the parser, which uses
//   the shared arithmetic unit when a factor or term is combined:
//     multiply: shift-add, ending once the remaining multiplier bits are
//               all zero
//     divide/modulo: bit-serial restoring divider
//   One character can use the multiplier and then the divider.
//   s_ready is high only while the sequencer is idle.
//   The result sits in an output register; the next character is accepted
//   while it waits. If another result is due before it is taken, the parser
//   holds until m_ready frees the register.
//   Reset (aresetn low, synchronous) clears the parser to an empty expression
//   and drops m_valid.
// ----------------------------------------------------------------------------
module integer_expression_evaluator_core
    import iee_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_code,
    input  logic                          s_end_of_input,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_result_value,
    output logic [7:0]                    m_stop_char,
    output logic                          m_ended_by_eof,
    output logic                          m_divide_error
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    fsm_t           state_reg, state_next;
    phase_t         phase_reg, phase_next;
    term_op_t       term_op_reg, term_op_next;
    logic [W-1:0]   sum_reg, sum_next;
    logic           sum_minus_reg, sum_minus_next;
    logic [W-1:0]   term_reg, term_next;
    logic [W-1:0]   factor_reg, factor_next;
    logic [W-1:0]   digit_reg, digit_next;
    logic           fault_reg, fault_next;
    logic [7:0]     char_reg, char_next;
    logic           eof_reg, eof_next;

    // shared arithmetic unit
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   opa_reg, opa_next;
    logic [W-1:0]   opb_reg, opb_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           to_term_reg, to_term_next;
    logic           want_rem_reg, want_rem_next;
    logic           neg_reg, neg_next;

    // output register
    logic           m_valid_reg;
    logic [W-1:0]   out_value_reg;
    logic [7:0]     out_char_reg;
    logic           out_eof_reg;
    logic           out_fault_reg;

    logic           emit;
    logic           out_free;
    logic           dig, blank;
    logic [3:0]     char_off;
    logic [W-1:0]   digit_val;
    logic [W-1:0]   digit_x10;
    logic [W-1:0]   mag_a, mag_b;
    logic [W:0]     rem_shift;
    logic [W:0]     rem_diff;
    logic [W-1:0]   div_res;

    assign out_free  = !m_valid_reg || m_ready;
    assign dig       = !eof_reg && (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign blank     = !eof_reg && ((char_reg == CH_SPACE) || (char_reg == CH_TAB));
    // digit codes 0x30-0x39: the low nibble is the value
    assign char_off  = char_reg[3:0];
    assign digit_val = {{(W-4){1'b0}}, char_off};
    assign digit_x10 = (digit_reg << 3) + (digit_reg << 1) + digit_val;
    assign mag_a     = term_reg[W-1] ? (-term_reg) : term_reg;
    assign mag_b     = factor_reg[W-1] ? (-factor_reg) : factor_reg;
    assign rem_shift = {acc_reg, opa_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, opb_reg};
    assign div_res   = want_rem_reg ? acc_reg : opa_reg;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        term_op_next   = term_op_reg;
        sum_next       = sum_reg;
        sum_minus_next = sum_minus_reg;
        term_next      = term_reg;
        factor_next    = factor_reg;
        digit_next     = digit_reg;
        fault_next     = fault_reg;
        char_next      = char_reg;
        eof_next       = eof_reg;
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        cnt_next       = cnt_reg;
        to_term_next   = to_term_reg;
        want_rem_next  = want_rem_reg;
        neg_next       = neg_reg;
        emit           = 1'b0;

        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    char_next  = s_char_code;
                    eof_next   = s_end_of_input;
                    state_next = F_STEP;
                end
            end

            F_STEP: begin
                case (phase_reg)
                    PH_FACT: begin
                        if (blank) begin
                            state_next = F_IDLE;
                        end else if (dig) begin
                            digit_next = digit_val;
                            phase_next = PH_NUMB;
                            state_next = F_IDLE;
                        end else if (!eof_reg && char_reg == CH_LPAREN) begin
                            digit_next = '0;
                            phase_next = PH_PSTART;
                            state_next = F_IDLE;
                        end else begin
                            // factor complete: fold into the term
                            phase_next = PH_TERM;
                            case (term_op_reg)
                                OP_FIRST: begin
                                    term_next = factor_reg;
                                end
                                OP_MUL: begin
                                    acc_next     = '0;
                                    opa_next     = term_reg;
                                    opb_next     = factor_reg;
                                    to_term_next = 1'b1;
                                    state_next   = F_MUL;
                                end
                                default: begin
                                    if (factor_reg == '0) begin
                                        fault_next = 1'b1;
                                        term_next  = '0;
                                    end else begin
                                        acc_next      = '0;
                                        opa_next      = mag_a;
                                        opb_next      = mag_b;
                                        cnt_next      = CW'(W);
                                        want_rem_next = (term_op_reg == OP_MOD);
                                        neg_next      = (term_op_reg == OP_MOD) ?
                                                        term_reg[W-1] :
                                                        (term_reg[W-1] ^ factor_reg[W-1]);
                                        state_next    = F_DIV;
                                    end
                                end
                            endcase
                        end
                    end

                    PH_NUMB, PH_PSTART, PH_PNUMB: begin
                        if (dig) begin
                            if (phase_reg == PH_PSTART) begin
                                digit_next = digit_val;
                                phase_next = PH_PNUMB;
                            end else begin
                                digit_next = digit_x10;
                            end
                            state_next = F_IDLE;
                        end else begin
                            // number complete: factor *= number
                            acc_next     = '0;
                            opa_next     = factor_reg;
                            opb_next     = (phase_reg == PH_PSTART) ? '0 : digit_reg;
                            to_term_next = 1'b0;
                            if (phase_reg == PH_PSTART) begin
                                digit_next = '0;
                            end
                            phase_next   = (phase_reg == PH_NUMB) ? PH_FACT : PH_PCLOSE;
                            state_next   = F_MUL;
                        end
                    end

                    PH_PCLOSE: begin
                        phase_next = PH_FACT;
                        if (!eof_reg && char_reg == CH_RPAREN) begin
                            state_next = F_IDLE;
                        end
                    end

                    PH_TERM: begin
                        if (blank) begin
                            state_next = F_IDLE;
                        end else if (!eof_reg && (char_reg == CH_STAR ||
                                     char_reg == CH_SLASH || char_reg == CH_PERCENT)) begin
                            term_op_next = (char_reg == CH_STAR)  ? OP_MUL :
                                           (char_reg == CH_SLASH) ? OP_DIV : OP_MOD;
                            factor_next  = {{(W-1){1'b0}}, 1'b1};
                            phase_next   = PH_FACT;
                            state_next   = F_IDLE;
                        end else begin
                            sum_next   = sum_minus_reg ? (sum_reg - term_reg) :
                                                         (sum_reg + term_reg);
                            phase_next = PH_SUM;
                        end
                    end

                    PH_SUM: begin
                        if (blank) begin
                            state_next = F_IDLE;
                        end else if (!eof_reg && (char_reg == CH_PLUS ||
                                     char_reg == CH_MINUS)) begin
                            sum_minus_next = (char_reg == CH_MINUS);
                            term_op_next   = OP_FIRST;
                            term_next      = {{(W-1){1'b0}}, 1'b1};
                            factor_next    = {{(W-1){1'b0}}, 1'b1};
                            phase_next     = PH_FACT;
                            state_next     = F_IDLE;
                        end else if (out_free) begin
                            // expression done: emit word, start fresh
                            emit           = 1'b1;
                            sum_next       = '0;
                            sum_minus_next = 1'b0;
                            term_next      = {{(W-1){1'b0}}, 1'b1};
                            term_op_next   = OP_FIRST;
                            factor_next    = {{(W-1){1'b0}}, 1'b1};
                            digit_next     = '0;
                            phase_next     = PH_FACT;
                            fault_next     = 1'b0;
                            state_next     = F_IDLE;
                        end
                    end

                    default: begin
                        phase_next = PH_FACT;
                    end
                endcase
            end

            F_MUL: begin
                if (opb_reg == '0) begin
                    if (to_term_reg) begin
                        term_next = acc_reg;
                    end else begin
                        factor_next = acc_reg;
                    end
                    state_next = F_STEP;
                end else begin
                    if (opb_reg[0]) begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
            end

            F_DIV: begin
                if (cnt_reg == '0) begin
                    term_next  = neg_reg ? (-div_res) : div_res;
                    state_next = F_STEP;
                end else begin
                    // one restoring step: acc holds remainder, opa the quotient
                    if (!rem_diff[W]) begin
                        acc_next = rem_diff[W-1:0];
                        opa_next = {opa_reg[W-2:0], 1'b1};
                    end else begin
                        acc_next = rem_shift[W-1:0];
                        opa_next = {opa_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            phase_reg     <= PH_FACT;
            term_op_reg   <= OP_FIRST;
            sum_reg       <= '0;
            sum_minus_reg <= 1'b0;
            term_reg      <= {{(W-1){1'b0}}, 1'b1};
            factor_reg    <= {{(W-1){1'b0}}, 1'b1};
            digit_reg     <= '0;
            fault_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            term_op_reg   <= term_op_next;
            sum_reg       <= sum_next;
            sum_minus_reg <= sum_minus_next;
            term_reg      <= term_next;
            factor_reg    <= factor_next;
            digit_reg     <= digit_next;
            fault_reg     <= fault_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        eof_reg      <= eof_next;
        acc_reg      <= acc_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        cnt_reg      <= cnt_next;
        to_term_reg  <= to_term_next;
        want_rem_reg <= want_rem_next;
        neg_reg      <= neg_next;
        if (emit) begin
            out_value_reg <= sum_reg;
            out_char_reg  <= eof_reg ? 8'h00 : char_reg;
            out_eof_reg   <= eof_reg;
            out_fault_reg <= fault_reg;
        end
    end

    assign s_ready        = (state_reg == F_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = $signed(out_value_reg);
    assign m_stop_char    = out_char_reg;
    assign m_ended_by_eof = out_eof_reg;
    assign m_divide_error = out_fault_reg;

endmodule

>>> rtl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Port-level assertions for the expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module iee_checker
    import iee_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [VALUE_WIDTH-1:0] m_result_value,
    input logic [7:0]                    m_stop_char,
    input logic                          m_ended_by_eof,
    input logic                          m_divide_error
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) &&
            $stable(m_stop_char) && $stable(m_ended_by_eof) && $stable(m_divide_error))
        else $error("result word changed while stalled");

    // s_ready drops after each accepted character
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word in back-to-back cycles");

    a_eof_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ended_by_eof |-> m_stop_char == 8'h00)
        else $error("stop char not zero on end of input");

    // blanks, digits and operators are always consumed, never a stop char
    a_stop_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ended_by_eof |->
            m_stop_char != CH_SPACE && m_stop_char != CH_TAB &&
            m_stop_char != CH_PLUS && m_stop_char != CH_MINUS &&
            m_stop_char != CH_STAR && m_stop_char != CH_SLASH &&
            m_stop_char != CH_PERCENT &&
            !(m_stop_char >= CH_ZERO && m_stop_char <= CH_NINE))
        else $error("stop char is one the parser consumes");

endmodule

bind integer_expression_evaluator_core iee_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_iee_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_stop_char    (m_stop_char),
    .m_ended_by_eof (m_ended_by_eof),
    .m_divide_error (m_divide_error)
);
